// ===== hdl/rtc3w_pkg.sv =====
// package for the three-wire rtc serial master: types, codes and constants
package rtc3w_pkg;

    localparam int unsigned HALF_PERIOD_WIDTH = 16;
    localparam logic [HALF_PERIOD_WIDTH-1:0] HALF_PERIOD_DEFAULT = 16'd10;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [7:0] READ_FLAG = 8'h01;
    localparam logic [7:0] TOP_BIT   = 8'h80;

    localparam logic [3:0] BIT_FIRST_DATA = 4'd8;
    localparam logic [3:0] BIT_LAST       = 4'd15;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_START,
        PH_HIGH,
        PH_LOW
    } phase_t;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] reg_address;
        logic [7:0] write_data;
        logic       data_pin;
    } item_t;

    typedef struct packed {
        logic       clock_pin;
        logic       data_out;
        logic       data_drive;
        logic       chip_enable;
        logic       busy_res;
        logic       access_done;
        logic [7:0] read_value;
    } result_t;

endpackage

// ===== hdl/rtc3w_seq.sv =====
// bit-level sequencer: one tick per accepted item, result from the next state
module rtc3w_seq
    import rtc3w_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step,
    input  item_t                        item,
    input  logic [HALF_PERIOD_WIDTH-1:0] half_period,
    output result_t                      result
);

    phase_t                       phase_reg, phase_next;
    logic [3:0]                   bit_index_reg, bit_index_next;
    logic [HALF_PERIOD_WIDTH-1:0] tick_count_reg, tick_count_next;
    logic [7:0]                   shift_out_reg, shift_out_next;
    logic [7:0]                   shift_in_reg, shift_in_next;
    logic [7:0]                   write_hold_reg, write_hold_next;
    logic                         clock_level_reg, clock_level_next;
    logic                         enable_level_reg, enable_level_next;
    logic                         is_read_reg, is_read_next;
    logic                         out_level_reg, out_level_next;
    logic                         driving_reg, driving_next;

    logic                         request;
    logic                         tick_done;
    logic                         start_bit;
    logic                         done_tick;
    logic [3:0]                   begin_index;
    logic [7:0]                   out_source;

    assign request   = (item.operation == OP_WRITE) || (item.operation == OP_READ);
    assign tick_done = (tick_count_reg >= half_period);

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_IDLE:
            begin
                if (request)
                begin
                    phase_next = PH_START;
                end
            end
            PH_START:
            begin
                phase_next = PH_HIGH;
            end
            PH_HIGH:
            begin
                if (tick_done)
                begin
                    phase_next = PH_LOW;
                end
            end
            PH_LOW:
            begin
                if (tick_done)
                begin
                    phase_next = (bit_index_reg >= BIT_LAST) ? PH_IDLE : PH_HIGH;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    assign start_bit = (phase_reg == PH_START) ||
                       ((phase_reg == PH_LOW) && tick_done && (bit_index_reg < BIT_LAST));
    assign begin_index = (phase_reg == PH_START) ? 4'd0 : bit_index_reg + 4'd1;
    assign out_source  = (begin_index == BIT_FIRST_DATA) ? write_hold_reg : shift_out_reg;

    // datapath
    always_comb
    begin
        bit_index_next    = bit_index_reg;
        tick_count_next   = tick_count_reg;
        shift_out_next    = shift_out_reg;
        shift_in_next     = shift_in_reg;
        write_hold_next   = write_hold_reg;
        clock_level_next  = clock_level_reg;
        enable_level_next = enable_level_reg;
        is_read_next      = is_read_reg;
        out_level_next    = out_level_reg;
        driving_next      = driving_reg;
        done_tick         = 1'b0;

        case (phase_reg)
            PH_IDLE:
            begin
                if (request)
                begin
                    is_read_next      = (item.operation == OP_READ);
                    shift_out_next    = (item.operation == OP_READ) ?
                                        (item.reg_address | READ_FLAG) : item.reg_address;
                    write_hold_next   = item.write_data;
                    bit_index_next    = 4'd0;
                    tick_count_next   = '0;
                    clock_level_next  = 1'b0;
                    enable_level_next = 1'b0;
                    driving_next      = 1'b1;
                end
            end
            PH_HIGH:
            begin
                if (tick_done)
                begin
                    clock_level_next = 1'b0;
                    tick_count_next  = HALF_PERIOD_WIDTH'(1);
                end
                else
                begin
                    tick_count_next = tick_count_reg + HALF_PERIOD_WIDTH'(1);
                end
            end
            PH_LOW:
            begin
                if (!tick_done)
                begin
                    tick_count_next = tick_count_reg + HALF_PERIOD_WIDTH'(1);
                end
                else if (bit_index_reg >= BIT_LAST)
                begin
                    clock_level_next  = 1'b1;
                    enable_level_next = 1'b0;
                    driving_next      = 1'b1;
                    tick_count_next   = '0;
                    done_tick         = 1'b1;
                end
            end
            default:
            begin
                enable_level_next = 1'b1;
            end
        endcase

        // start of one clock bit
        if (start_bit)
        begin
            bit_index_next = begin_index;
            if ((begin_index >= BIT_FIRST_DATA) && is_read_reg)
            begin
                driving_next  = 1'b0;
                shift_in_next = (shift_in_reg >> 1) | (item.data_pin ? TOP_BIT : 8'h00);
            end
            else
            begin
                driving_next   = 1'b1;
                out_level_next = out_source[0];
                shift_out_next = out_source >> 1;
            end
            clock_level_next = 1'b1;
            tick_count_next  = HALF_PERIOD_WIDTH'(1);
        end
    end

    // outputs
    always_comb
    begin
        result.clock_pin   = clock_level_next;
        result.data_out    = out_level_next;
        result.data_drive  = driving_next;
        result.chip_enable = enable_level_next;
        result.busy_res    = (phase_reg != PH_IDLE) || (phase_next != PH_IDLE);
        result.access_done = done_tick;
        result.read_value  = shift_in_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            bit_index_reg    <= '0;
            tick_count_reg   <= '0;
            shift_out_reg    <= '0;
            shift_in_reg     <= '0;
            write_hold_reg   <= '0;
            clock_level_reg  <= 1'b0;
            enable_level_reg <= 1'b0;
            is_read_reg      <= 1'b0;
            out_level_reg    <= 1'b0;
            driving_reg      <= 1'b1;
        end
        else if (step)
        begin
            phase_reg        <= phase_next;
            bit_index_reg    <= bit_index_next;
            tick_count_reg   <= tick_count_next;
            shift_out_reg    <= shift_out_next;
            shift_in_reg     <= shift_in_next;
            write_hold_reg   <= write_hold_next;
            clock_level_reg  <= clock_level_next;
            enable_level_reg <= enable_level_next;
            is_read_reg      <= is_read_next;
            out_level_reg    <= out_level_next;
            driving_reg      <= driving_next;
        end
    end

endmodule

// ===== hdl/three_wire_rtc_serial_master_core.sv =====
// top level of the three-wire rtc serial master: config register, sequencer, output buffer
// an accepted item's result is registered in the output register, or in the skid register while the output stalls
// throughput: one item per cycle while in_stall is low; the sequencer advances one tick per accepted item
// a two-entry output buffer keeps input accepting for one more item while the output stalls
// reset: asynchronous, active low; sequencer idle with its ce level low and data line driven,
// half period back to RESET_HALF_PERIOD, out_valid low; the output register itself is not reset
module three_wire_rtc_serial_master_core
    import rtc3w_pkg::*;
#(
    parameter logic [HALF_PERIOD_WIDTH-1:0] RESET_HALF_PERIOD = HALF_PERIOD_DEFAULT
)
(
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [HALF_PERIOD_WIDTH-1:0] cfg_data,

    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   operation,
    input  logic [7:0]                   reg_address,
    input  logic [7:0]                   write_data,
    input  logic                         data_pin,

    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         clock_pin,
    output logic                         data_out,
    output logic                         data_drive,
    output logic                         chip_enable,
    output logic                         busy_res,
    output logic                         access_done,
    output logic [7:0]                   read_value
);

    logic [HALF_PERIOD_WIDTH-1:0] half_period_reg;
    logic                         in_accept;
    logic                         out_free;
    item_t                        item;
    result_t                      result;
    result_t                      out_reg, out_next;
    result_t                      skid_reg, skid_next;
    logic                         out_valid_reg, out_valid_next;
    logic                         skid_valid_reg, skid_valid_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg <= RESET_HALF_PERIOD;
        end
        else if (cfg_valid && cfg_ready)
        begin
            half_period_reg <= cfg_data;
        end
    end

    assign item.operation   = operation;
    assign item.reg_address = reg_address;
    assign item.write_data  = write_data;
    assign item.data_pin    = data_pin;

    assign in_stall  = skid_valid_reg;
    assign in_accept = in_valid && !skid_valid_reg;

    rtc3w_seq u_seq
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (in_accept),
        .item        (item),
        .half_period (half_period_reg),
        .result      (result)
    );

    // output register with skid stage
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else if (in_accept)
            begin
                out_next       = result;
                out_valid_next = 1'b1;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (in_accept)
        begin
            skid_next       = result;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid   = out_valid_reg;
    assign clock_pin   = out_reg.clock_pin;
    assign data_out    = out_reg.data_out;
    assign data_drive  = out_reg.data_drive;
    assign chip_enable = out_reg.chip_enable;
    assign busy_res    = out_reg.busy_res;
    assign access_done = out_reg.access_done;
    assign read_value  = out_reg.read_value;

endmodule
